// ----- design/apcm_pkg.sv -----
// apcm_pkg: shared types, register indexes and conversion functions
// for the a-law / linear pcm codec. no dependencies.
// used by apcm_cfg, apcm_conv, alaw_pcm_codec and apcm_chk.
package apcm_pkg;

    localparam int SampleW  = 32;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 32;

    // register indexes on the configuration channel
    typedef enum logic [CfgIdxW-1:0] {
        REG_DIRECTION      = 4'd0,
        REG_WIDTH_CODE     = 4'd1,
        REG_SIGNED_SAMPLES = 4'd2,
        REG_BYTE_SWAP      = 4'd3
    } reg_idx_t;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_24 = 2'd2,
        WIDTH_32 = 2'd3
    } width_t;

    typedef struct packed {
        dir_t   direction;
        width_t width_code;
        logic   signed_samples;
        logic   byte_swap;
    } cfg_t;

    localparam logic [7:0] MaskPos = 8'hD5;
    localparam logic [7:0] MaskNeg = 8'h55;
    localparam logic [7:0] TopCode = 8'h7F;
    localparam logic [15:0] SegBias = 16'h0108;

    localparam logic [15:0] SegEnds [8] = '{
        16'h00FF, 16'h01FF, 16'h03FF, 16'h07FF,
        16'h0FFF, 16'h1FFF, 16'h3FFF, 16'h7FFF
    };

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // signed 16-bit value to a-law byte
    function automatic logic [7:0] alaw_encode(input logic [15:0] v16);
        logic [7:0]  mask;
        logic [15:0] mag;
        logic [15:0] inv;
        logic [3:0]  seg;
        logic [3:0]  mant;
        mask = MaskPos;
        mag  = {1'b0, v16[14:0]};
        inv  = ~v16;
        seg  = 4'd8;
        mant = 4'd0;
        if (v16[15])
        begin
            mask = MaskNeg;
            // magnitude minus 8, floored at zero: ~v16 - 7
            mag = (inv >= 16'd7) ? 16'(inv - 16'd7) : 16'd0;
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (mag <= SegEnds[i])
                seg = 4'(i);
        end
        case (seg[2:0])
            3'd0, 3'd1: mant = mag[7:4];
            3'd2:       mant = mag[8:5];
            3'd3:       mant = mag[9:6];
            3'd4:       mant = mag[10:7];
            3'd5:       mant = mag[11:8];
            3'd6:       mant = mag[12:9];
            3'd7:       mant = mag[13:10];
            default:    mant = 4'd0;
        endcase
        if (seg[3])
            return TopCode ^ mask;
        return {1'b0, seg[2:0], mant} ^ mask;
    endfunction

    // a-law byte to signed 16-bit value
    function automatic logic [15:0] alaw_decode(input logic [7:0] code);
        logic [7:0]  a;
        logic [15:0] t;
        logic [15:0] tb;
        a  = code ^ MaskNeg;
        t  = {8'd0, a[3:0], 4'd0};
        tb = t + SegBias;
        case (a[6:4])
            3'd0:    t = t + 16'd8;
            3'd1:    t = tb;
            3'd2:    t = tb << 1;
            3'd3:    t = tb << 2;
            3'd4:    t = tb << 3;
            3'd5:    t = tb << 4;
            3'd6:    t = tb << 5;
            3'd7:    t = tb << 6;
            default: t = tb;
        endcase
        if (a[7])
            return t;
        return 16'(16'd0 - t);
    endfunction

endpackage

// ----- design/apcm_cfg.sv -----
// apcm_cfg: configuration register bank of the codec, written over
// its own valid/ready channel. depends on apcm_pkg.
module apcm_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [apcm_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [apcm_pkg::CfgDataW-1:0] cfg_data,
    output apcm_pkg::cfg_t               cfg
);

    apcm_pkg::cfg_t cfg_reg;
    apcm_pkg::cfg_t cfg_next;

    // the bank takes a beat in every cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                apcm_pkg::REG_DIRECTION:
                    cfg_next.direction = apcm_pkg::dir_t'(cfg_data[0]);
                apcm_pkg::REG_WIDTH_CODE:
                    cfg_next.width_code = apcm_pkg::width_t'(cfg_data[1:0]);
                apcm_pkg::REG_SIGNED_SAMPLES:
                    cfg_next.signed_samples = cfg_data[0];
                apcm_pkg::REG_BYTE_SWAP:
                    cfg_next.byte_swap = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction      <= apcm_pkg::DIR_ENCODE;
            cfg_reg.width_code     <= apcm_pkg::WIDTH_16;
            cfg_reg.signed_samples <= 1'b1;
            cfg_reg.byte_swap      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/apcm_conv.sv -----
// apcm_conv: combinational sample conversion between a linear container
// and an a-law byte, in either direction. depends on apcm_pkg.
module apcm_conv
(
    input  apcm_pkg::cfg_t                cfg,
    input  logic [apcm_pkg::SampleW-1:0]  sample,
    output logic [apcm_pkg::SampleW-1:0]  result
);

    logic [31:0] unswapped;
    logic [15:0] enc_v16;
    logic [15:0] dec_v16;
    logic [15:0] dec16;
    logic [31:0] dec32;
    logic [31:0] dec_out;
    logic        flip;

    assign flip = ~cfg.signed_samples;

    // encode side: bring the container to a 16-bit two's complement value
    always_comb
    begin
        unswapped = cfg.byte_swap ? apcm_pkg::swap32(sample) : sample;
        case (cfg.width_code)
            apcm_pkg::WIDTH_8:
                enc_v16 = {sample[7:0], 8'd0};
            apcm_pkg::WIDTH_16:
                enc_v16 = cfg.byte_swap ? apcm_pkg::swap16(sample[15:0]) : sample[15:0];
            apcm_pkg::WIDTH_24:
                enc_v16 = unswapped[23:8];
            apcm_pkg::WIDTH_32:
                enc_v16 = unswapped[31:16];
            default:
                enc_v16 = unswapped[31:16];
        endcase
        // offset binary: the container's top bit lands on bit 15
        enc_v16[15] = enc_v16[15] ^ flip;
    end

    // decode side: expand and place into the container
    assign dec_v16 = apcm_pkg::alaw_decode(sample[7:0]);

    always_comb
    begin
        dec16 = {dec_v16[15] ^ flip, dec_v16[14:0]};
        dec32 = 32'd0;
        case (cfg.width_code)
            apcm_pkg::WIDTH_8:
                dec_out = {24'd0, dec16[15:8]};
            apcm_pkg::WIDTH_16:
                dec_out = {16'd0, cfg.byte_swap ? apcm_pkg::swap16(dec16) : dec16};
            apcm_pkg::WIDTH_24:
            begin
                dec32   = {8'd0, dec16, 8'd0};
                dec_out = cfg.byte_swap ? apcm_pkg::swap32(dec32) : dec32;
            end
            apcm_pkg::WIDTH_32:
            begin
                dec32   = {dec16, 16'd0};
                dec_out = cfg.byte_swap ? apcm_pkg::swap32(dec32) : dec32;
            end
            default:
                dec_out = 32'd0;
        endcase
    end

    assign result = (cfg.direction == apcm_pkg::DIR_DECODE)
                  ? dec_out
                  : {24'd0, apcm_pkg::alaw_encode(enc_v16)};

endmodule

// ----- design/alaw_pcm_codec.sv -----
// alaw_pcm_codec: top level of the a-law / linear pcm codec, two register
// stages around the conversion logic. depends on apcm_pkg, apcm_cfg, apcm_conv.
//
// usage:
//   s_axis carries one sample per beat in tdata; when encoding it is a linear
//   container of 8, 16, 24 or 32 bits, when decoding an a-law byte in bits 7..0.
//   m_axis returns one result per input beat, in order: the a-law byte in bits
//   7..0 (upper bits zero) or the linear container, zero-extended.
//   the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   sets direction, width code, signedness and byte swap; cfg_ready is always
//   high; the user writes only while no beat is in flight (not enforced).
// timing:
//   a beat taken sits in the input register, passes the conversion logic and
//   lands in the result register, where m_axis_tvalid rises; it leaves from
//   there once m_axis_tready is high.
//   throughput is one beat per cycle while m_axis_tready stays high, set by
//   the single pass through the conversion logic.
// reset: rst_n clears the valid flags of both stages and loads the
//   configuration registers with encode, 16-bit, signed, no swap.
// stalls: when m_axis_tready is low the result holds; the input register
//   still takes one more beat if it is empty, then s_axis_tready drops until the result moves.
module alaw_pcm_codec
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [apcm_pkg::SampleW-1:0] s_axis_tdata,   // [31:0] sample_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [apcm_pkg::SampleW-1:0] m_axis_tdata,   // [31:0] sample_out
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [apcm_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [apcm_pkg::CfgDataW-1:0] cfg_data
);

    apcm_pkg::cfg_t cfg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [apcm_pkg::SampleW-1:0] in_data_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [apcm_pkg::SampleW-1:0] out_data_reg;
    logic [apcm_pkg::SampleW-1:0] conv_result;
    logic                         out_ready;
    logic                         in_ready;

    apcm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apcm_conv u_conv
    (
        .cfg    (cfg),
        .sample (in_data_reg),
        .result (conv_result)
    );

    assign out_ready = ~out_valid_reg | m_axis_tready;
    assign in_ready  = ~in_valid_reg | out_ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
            in_valid_next = s_axis_tvalid;
        if (out_ready)
            out_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata;
        if (out_ready && in_valid_reg)
            out_data_reg <= conv_result;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- design/apcm_chk.sv -----
// apcm_chk: port-level checks for alaw_pcm_codec, attached by bind.
// depends on apcm_pkg and the top level's ports.
module apcm_chk
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [apcm_pkg::SampleW-1:0] s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [apcm_pkg::SampleW-1:0] m_axis_tdata,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [apcm_pkg::CfgIdxW-1:0] cfg_index,
    input logic [apcm_pkg::CfgDataW-1:0] cfg_data
);

    // shadow copies of the registers that bound the result's width
    logic       dir_reg;
    logic [1:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= apcm_pkg::DIR_ENCODE;
            width_reg <= apcm_pkg::WIDTH_16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == apcm_pkg::REG_DIRECTION)
                dir_reg <= cfg_data[0];
            if (cfg_index == apcm_pkg::REG_WIDTH_CODE)
                width_reg <= cfg_data[1:0];
        end
    end

    // a waiting input beat holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a draining output never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // encoded bytes carry zeros above bit 7
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir_reg == apcm_pkg::DIR_ENCODE |-> m_axis_tdata[31:8] == 24'd0)
        else $error("encoded beat has upper bits set");

    // 8-bit and 16-bit containers are zero-extended
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dir_reg == apcm_pkg::DIR_DECODE
            && (width_reg == apcm_pkg::WIDTH_8 || width_reg == apcm_pkg::WIDTH_16)
        |-> m_axis_tdata[31:16] == 16'd0
            && (width_reg == apcm_pkg::WIDTH_16 || m_axis_tdata[15:8] == 8'd0))
        else $error("narrow container not zero-extended");

endmodule

bind alaw_pcm_codec apcm_chk u_apcm_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
